>>> rtl/core/bf2d_pkg.sv
package bf2d_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ROW_LIMIT  = 2048;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int COL_W      = IDX_W + 1;
    localparam int ROW_W      = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 32;
    localparam int SUM_W      = 36;
    localparam int CMP_W      = ((CFG_W > COL_W) ? CFG_W : COL_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0] CFG_RESET = 12'd2;

    // Where the next pixel falls in the frame.
    typedef struct packed {
        logic             odd_col;
        logic             odd_row;
        logic [IDX_W-1:0] idx;
        logic             last;
    } pos_t;

    // Four 9-bit channel sums of a horizontal pair, alpha in the top field.
    function automatic logic [SUM_W-1:0] pair_sums(input logic [PIX_W-1:0] p,
                                                   input logic [PIX_W-1:0] q);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int s = 0; s < 4; s++)
        begin
            r[s*9 +: 9] = {1'b0, p[s*8 +: 8]} + {1'b0, q[s*8 +: 8]};
        end
        return r;
    endfunction

    // Adds the two rows of pair sums and truncates each channel by four.
    function automatic logic [PIX_W-1:0] average(input logic [SUM_W-1:0] top,
                                                 input logic [SUM_W-1:0] bottom);
        logic [PIX_W-1:0] r;
        logic [9:0]       c;
        r = '0;
        for (int s = 0; s < 4; s++)
        begin
            c = {1'b0, top[s*9 +: 9]} + {1'b0, bottom[s*9 +: 9]};
            r[s*8 +: 8] = c[9:2];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/box_filter_2x2_downsample.sv
// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     in_pixel
// out       source     out_valid / out_ready   out_pixel, last_out
// cfg       sink       cfg_wr_en               cfg_index, cfg_data
//
// One source pixel is accepted every clock while in_ready is high; the sums of
// an odd row's odd-column pair and its line buffer read fill the middle stage.
// Reset clears the counters, the pipeline valids and restores both sizes to 2;
// the line buffer is not cleared, each even row writes it before it is read.
// When the output word is held, one further word waits in the middle stage and
// in_ready drops only once both are full.
module box_filter_2x2_downsample (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bf2d_pkg::PIX_W-1:0]     in_pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bf2d_pkg::PIX_W-1:0]     out_pixel,
    output logic                           last_out,
    input  logic                           cfg_wr_en,
    input  logic [bf2d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bf2d_pkg::CFG_W-1:0]     cfg_data
);
    import bf2d_pkg::*;

    logic [CFG_W-1:0] width_reg, height_reg;
    logic [PIX_W-1:0] held_reg;
    logic             s1_valid_reg, s1_last_reg;
    logic [SUM_W-1:0] s1_sums_reg;
    logic [SUM_W-1:0] rd_reg;
    logic             out_valid_reg, out_last_reg;
    logic [PIX_W-1:0] out_pixel_reg;

    logic [SUM_W-1:0] line_mem [LINE_DEPTH];

    pos_t             pos;
    logic             accept, out_free, s1_move;
    logic             line_wr, line_rd;
    logic [SUM_W-1:0] sums;

    bf2d_position u_position (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .src_width  (width_reg),
        .src_height (height_reg),
        .pos        (pos)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;
    assign sums     = pair_sums(held_reg, in_pixel);
    assign line_wr  = accept && pos.odd_col && !pos.odd_row;
    assign line_rd  = accept && pos.odd_col && pos.odd_row;

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign last_out  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_RESET;
            height_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:  width_reg  <= cfg_data;
                REG_SRC_HEIGHT: height_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Rows alternate between writing and reading, so no entry is read while
    // its write is still in flight.
    always_ff @(posedge clk)
    begin
        if (line_wr)
            line_mem[pos.idx] <= sums;
        if (line_rd)
            rd_reg <= line_mem[pos.idx];
    end

    always_ff @(posedge clk)
    begin
        if (accept && !pos.odd_col)
            held_reg <= in_pixel;
        if (line_rd)
        begin
            s1_sums_reg <= sums;
            s1_last_reg <= pos.last;
        end
        if (s1_move)
        begin
            out_pixel_reg <= average(rd_reg, s1_sums_reg);
            out_last_reg  <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (line_rd)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (s1_move)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

>>> rtl/core/bf2d_position.sv
module bf2d_position (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic [bf2d_pkg::CFG_W-1:0] src_width,
    input  logic [bf2d_pkg::CFG_W-1:0] src_height,
    output bf2d_pkg::pos_t             pos
);
    import bf2d_pkg::*;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] w_eff, h_eff, w_raw, h_raw;
    logic [CMP_W-1:0] col_inc, row_inc;

    always_comb
    begin
        w_raw = CMP_W'(src_width);
        h_raw = CMP_W'(src_height);
        // Oversized widths and heights are clipped; zero behaves as one.
        if (w_raw > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else if (w_raw == '0)
            w_eff = CMP_W'(1);
        else
            w_eff = w_raw;
        if (h_raw > CMP_W'(ROW_LIMIT))
            h_eff = CMP_W'(ROW_LIMIT);
        else if (h_raw == '0)
            h_eff = CMP_W'(1);
        else
            h_eff = h_raw;

        col_inc = CMP_W'(col_reg) + CMP_W'(1);
        row_inc = CMP_W'(row_reg) + CMP_W'(1);

        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (col_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end

        pos.odd_col = col_reg[0];
        pos.odd_row = row_reg[0];
        pos.idx     = col_reg[COL_W-1:1];
        pos.last    = (col_inc == (w_eff & ~CMP_W'(1))) &&
                      (row_inc == (h_eff & ~CMP_W'(1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
